// ===== rtl/core/ready_table_cpu_dispatcher_unit_defines.svh =====
// Assertion macros for the ready table dispatcher.
`ifndef READY_TABLE_CPU_DISPATCHER_UNIT_DEFINES_SVH
`define READY_TABLE_CPU_DISPATCHER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RTD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RTD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RTD_ASSERT(label, clk, rst_n, prop)
`define RTD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/rtd_pkg.sv =====
// Shared types and constants of the ready table dispatcher.
`default_nettype none
package rtd_pkg;
  localparam logic [1:0] CMD_ADMIT    = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_SJF  = 2'd2;
  localparam logic [1:0] POL_SRTF = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BUSY   = 2'd3;

  localparam logic [15:0] SEQ_MID = 16'h8000;
  localparam logic [15:0] QUANTUM_RESET = 16'd5;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_SLICE  = 2'd1;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [15:0] proc;
    logic [15:0] burst;
    logic [31:0] entered;
    logic        was_cut;
    logic [15:0] order;
  } slot_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        dispatched;
    logic [15:0] chosen_id;
    logic [15:0] slice_len;
    logic [15:0] left_over;
    logic        did_preempt;
    logic [15:0] preempted_id;
    logic [47:0] arrival_sum;
    logic [47:0] wait_sum;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/core/ready_table_cpu_dispatcher_unit.sv =====
// Ready table CPU dispatcher: admit, schedule and release over a slot memory.
// The input channel carries one command word: admit, schedule or release.
// Each accepted word yields exactly one result word on the output channel.
// Admit and release pass through the done and emit states to the result.
// Schedule scans the slot memory one entry a cycle to find the first entry or
// the shortest burst, then fetches the chosen entry and, on a preemption,
// writes the runner back; the single read port sets the pace of the scan.
// One word is in work at a time; a new word is accepted once the previous
// result has moved into the output register, even while that register waits.
// Per-slot valid bits sit in flip-flops and reset clears them at once, so
// no clearing pass is needed. Reset also empties the CPUs, zeroes the
// totals, sets policy to first come first serve and the quantum to 5.
// When the receiver stalls, the result holds in the output register and the
// block stops accepting after finishing at most one more word.
// Configuration uses an APB-style port with pready always high; policy lies
// at address 0 and the quantum at address 4.
`default_nettype none
`include "ready_table_cpu_dispatcher_unit_defines.svh"
module ready_table_cpu_dispatcher_unit #(
  parameter int TABLE_SLOTS = 16,
  parameter int CPU_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [1:0]  in_cpu_index,
  input  wire logic [15:0] in_proc_id,
  input  wire logic [15:0] in_burst_len,
  input  wire logic        in_resumed,
  input  wire logic [31:0] in_now,
  input  wire logic [15:0] in_running_left,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_dispatched,
  output logic [15:0]      out_chosen_id,
  output logic [15:0]      out_slice_len,
  output logic [15:0]      out_left_over,
  output logic             out_did_preempt,
  output logic [15:0]      out_preempted_id,
  output logic [47:0]      out_arrival_sum,
  output logic [47:0]      out_wait_sum,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SCW = AW + 1;
  localparam logic [SCW-1:0] LAST_SLOT = SCW'(TABLE_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LAST  = 6'b000100,
    S_FETCH = 6'b001000,
    S_DONE  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [1:0]  policy_r;
  logic [15:0] slice_r;
  logic [1:0]  reg_sel;
  assign reg_sel = paddr[2] ? rtd_pkg::REG_SLICE : rtd_pkg::REG_POLICY;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= rtd_pkg::POL_FCFS;
      slice_r  <= rtd_pkg::QUANTUM_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      unique case (reg_sel)
        rtd_pkg::REG_POLICY: policy_r <= pwdata[1:0];
        default:             slice_r  <= pwdata[15:0];
      endcase
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr == 3'd0) prdata = {30'd0, policy_r};
    else if (paddr == 3'd4) prdata = {16'd0, slice_r};
  end

  // Latched command word.
  logic [1:0]  cmd_r;
  logic [15:0] pid_r, burst_r, rleft_r;
  logic [1:0]  cpu_r;
  logic        res_r;
  logic [31:0] now_r;

  logic [TABLE_SLOTS-1:0] valid_r;
  logic [CPU_COUNT-1:0]   busy_r;
  logic [15:0]            cpu_proc_r [CPU_COUNT];
  logic [15:0]            front_r, back_r;
  logic [47:0]            arr_r, wait_r;

  // Scan state.
  logic [SCW-1:0] scan_r;
  logic [AW-1:0]  rd_idx_r;
  logic           rd_live_r;
  logic           best_ok_r;
  logic [AW-1:0]  best_idx_r;
  logic [15:0]    best_key_r, best_burst_r;

  // Output register, fed from a staging register that holds a finished word.
  logic           out_valid_r;
  rtd_pkg::result_t res_q_r, res_s_r, res_nxt;

  logic in_fire;
  assign in_ready = state_r == S_IDLE;
  assign in_fire = in_valid && in_ready;

  // Slot memory.
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  rtd_pkg::slot_t mem_wdata, mem_rdata;
  rtd_slot_mem #(.DEPTH(TABLE_SLOTS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // Lowest free slot.
  logic          free_ok;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic cpu_ok;
  logic [CW-1:0] cpu_sel;
  assign cpu_ok = 32'(cpu_r) < CPU_COUNT;
  assign cpu_sel = CW'(cpu_r);

  // Comparison of the entry read last cycle against the best so far.
  logic [15:0] cur_key;
  logic        take;
  logic        by_burst;
  assign by_burst = policy_r[1];
  assign cur_key = mem_rdata.order - front_r;
  always_comb begin
    take = 1'b0;
    if (rd_live_r && valid_r[rd_idx_r]) begin
      if (!best_ok_r) take = 1'b1;
      else if (by_burst)
        take = mem_rdata.burst < best_burst_r ||
               (mem_rdata.burst == best_burst_r && cur_key < best_key_r);
      else take = cur_key < best_key_r;
    end
  end

  // Decision once the chosen entry is fetched.
  logic        srtf, busy_c, preempt_c, go_c;
  logic [1:0]  sched_status;
  logic [32:0] wdiff;
  logic [48:0] arr_add, wait_add;
  logic        add_arr;
  always_comb begin
    srtf = policy_r == rtd_pkg::POL_SRTF;
    busy_c = busy_r[cpu_sel];
    go_c = 1'b0;
    sched_status = rtd_pkg::ST_OK;
    if (!srtf && busy_c) sched_status = rtd_pkg::ST_BUSY;
    else if (!best_ok_r) sched_status = rtd_pkg::ST_NONE;
    else if (srtf && busy_c && rleft_r <= mem_rdata.burst) sched_status = rtd_pkg::ST_BUSY;
    else go_c = 1'b1;
    preempt_c = go_c && srtf && busy_c;
    add_arr = policy_r == rtd_pkg::POL_FCFS || policy_r == rtd_pkg::POL_SJF ||
              !mem_rdata.was_cut;
    wdiff = {1'b0, now_r} - {1'b0, mem_rdata.entered};
    arr_add = {1'b0, arr_r} + {17'd0, now_r};
    wait_add = {1'b0, wait_r} + {17'd0, wdiff[31:0]};
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.status = rtd_pkg::ST_NONE;
    res_nxt.arrival_sum = arr_r;
    res_nxt.wait_sum = wait_r;
    if (cmd_r == rtd_pkg::CMD_ADMIT) begin
      res_nxt.status = free_ok ? rtd_pkg::ST_OK : rtd_pkg::ST_FULL;
    end else if (cmd_r == rtd_pkg::CMD_RELEASE && cpu_ok) begin
      res_nxt.status = rtd_pkg::ST_OK;
    end else if (cmd_r == rtd_pkg::CMD_SCHEDULE && cpu_ok) begin
      res_nxt.status = sched_status;
      if (go_c) begin
        res_nxt.dispatched = 1'b1;
        res_nxt.chosen_id = mem_rdata.proc;
        res_nxt.slice_len = mem_rdata.burst;
        if (policy_r == rtd_pkg::POL_RR && mem_rdata.burst > slice_r) begin
          res_nxt.slice_len = slice_r;
          res_nxt.left_over = mem_rdata.burst - slice_r;
        end
        res_nxt.did_preempt = preempt_c;
        res_nxt.preempted_id = preempt_c ? cpu_proc_r[cpu_sel] : 16'd0;
        if (add_arr) res_nxt.arrival_sum = arr_add[48] ? rtd_pkg::MAX48 : arr_add[47:0];
        if (!wdiff[32])
          res_nxt.wait_sum = wait_add[48] ? rtd_pkg::MAX48 : wait_add[47:0];
      end
    end
  end

  // Memory port control. The last scanned entry may itself win, so the fetch
  // address follows the comparison made in that cycle.
  always_comb begin
    mem_raddr = scan_r[AW-1:0];
    if (state_r == S_LAST) mem_raddr = take ? rd_idx_r : best_idx_r;
    mem_we = 1'b0;
    mem_waddr = free_idx;
    mem_wdata.proc = pid_r;
    mem_wdata.burst = burst_r;
    mem_wdata.entered = now_r;
    mem_wdata.was_cut = res_r;
    mem_wdata.order = back_r;
    if (state_r == S_DONE && cmd_r == rtd_pkg::CMD_ADMIT) mem_we = free_ok;
    if (state_r == S_FETCH && cmd_r == rtd_pkg::CMD_SCHEDULE && cpu_ok && preempt_c) begin
      mem_we = 1'b1;
      mem_waddr = best_idx_r;
      mem_wdata.proc = cpu_proc_r[cpu_sel];
      mem_wdata.burst = rleft_r;
      mem_wdata.was_cut = 1'b1;
      mem_wdata.order = front_r - 16'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = (in_command == rtd_pkg::CMD_SCHEDULE) ? S_SCAN : S_DONE;
      S_SCAN:  if (scan_r == LAST_SLOT) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EMIT;
      S_DONE:  state_nxt = S_EMIT;
      S_EMIT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [TABLE_SLOTS-1:0] valid_after;
  always_comb begin
    valid_after = valid_r;
    if (go_c) valid_after[best_idx_r] = preempt_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      busy_r <= '0;
      for (int c = 0; c < CPU_COUNT; c++) cpu_proc_r[c] <= 16'd0;
      front_r <= rtd_pkg::SEQ_MID;
      back_r <= rtd_pkg::SEQ_MID;
      arr_r <= '0;
      wait_r <= '0;
      out_valid_r <= 1'b0;
      rd_live_r <= 1'b0;
      best_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      rd_live_r <= state_r == S_SCAN;
      if (in_fire) begin
        best_ok_r <= 1'b0;
      end else if (take) begin
        best_ok_r <= 1'b1;
      end
      if (state_r == S_DONE && cmd_r == rtd_pkg::CMD_ADMIT && free_ok) begin
        valid_r[free_idx] <= 1'b1;
        back_r <= back_r + 16'd1;
      end
      if (state_r == S_DONE && cmd_r == rtd_pkg::CMD_RELEASE && cpu_ok) begin
        busy_r[cpu_sel] <= 1'b0;
        cpu_proc_r[cpu_sel] <= 16'd0;
      end
      if (state_r == S_FETCH && cmd_r == rtd_pkg::CMD_SCHEDULE && cpu_ok && go_c) begin
        valid_r <= valid_after;
        busy_r[cpu_sel] <= 1'b1;
        cpu_proc_r[cpu_sel] <= mem_rdata.proc;
        arr_r <= res_nxt.arrival_sum;
        wait_r <= res_nxt.wait_sum;
        if (valid_after == '0) begin
          front_r <= rtd_pkg::SEQ_MID;
          back_r <= rtd_pkg::SEQ_MID;
        end else if (preempt_c) begin
          front_r <= front_r - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command;
      cpu_r <= in_cpu_index;
      pid_r <= in_proc_id;
      burst_r <= in_burst_len;
      res_r <= in_resumed;
      now_r <= in_now;
      rleft_r <= in_running_left;
      scan_r <= '0;
    end else if (state_r == S_SCAN && scan_r != LAST_SLOT) begin
      scan_r <= scan_r + SCW'(1);
    end
    rd_idx_r <= scan_r[AW-1:0];
    if (take) begin
      best_idx_r <= rd_idx_r;
      best_key_r <= cur_key;
      best_burst_r <= mem_rdata.burst;
    end
    if (state_r == S_FETCH || state_r == S_DONE) res_s_r <= res_nxt;
    if (state_r == S_EMIT && (!out_valid_r || out_ready)) res_q_r <= res_s_r;
  end

  assign out_valid = out_valid_r;
  assign out_status = res_q_r.status;
  assign out_dispatched = res_q_r.dispatched;
  assign out_chosen_id = res_q_r.chosen_id;
  assign out_slice_len = res_q_r.slice_len;
  assign out_left_over = res_q_r.left_over;
  assign out_did_preempt = res_q_r.did_preempt;
  assign out_preempted_id = res_q_r.preempted_id;
  assign out_arrival_sum = res_q_r.arrival_sum;
  assign out_wait_sum = res_q_r.wait_sum;

  `RTD_ASSERT(a_accept_idle, clk, rst_n, in_fire |-> state_r == S_IDLE)
  `RTD_ASSERT(a_dispatch_busy, clk, rst_n, ($rose(out_valid_r) && out_dispatched) |-> busy_r != '0)
  `RTD_ASSERT(a_preempt_dispatch, clk, rst_n, (out_valid_r && out_did_preempt) |-> out_dispatched)
  `RTD_ASSERT(a_arrival_mono, clk, rst_n, arr_r >= $past(arr_r) || $past(!rst_n))
endmodule
`default_nettype wire

// ===== rtl/core/rtd_slot_mem.sv =====
// Synchronous slot memory, one write and one registered read port.
`default_nettype none
module rtd_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire rtd_pkg::slot_t  wdata,
  input  wire logic [AW-1:0]   raddr,
  output rtd_pkg::slot_t       rdata
);
  rtd_pkg::slot_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sim/ready_table_cpu_dispatcher_unit_tb.sv =====
// Self-checking testbench for the ready table CPU dispatcher.
module ready_table_cpu_dispatcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int CPUS = 4;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  cpu_index;
    logic [15:0] proc_id;
    logic [15:0] burst_len;
    logic        resumed;
    logic [31:0] now;
    logic [15:0] running_left;
  } word_t;

  // Scheduler state mirror that predicts the result of every accepted word.
  class dispatch_scoreboard;
    logic [1:0]  policy;
    logic [15:0] quantum;
    bit          valid [SLOTS];
    logic [15:0] proc [SLOTS];
    logic [15:0] burst [SLOTS];
    logic [31:0] entered [SLOTS];
    bit          was_cut [SLOTS];
    logic [15:0] order [SLOTS];
    logic [15:0] front_seq, back_seq;
    bit          busy [CPUS];
    logic [15:0] running [CPUS];
    logic [47:0] arrival_total, wait_total;
    rtd_pkg::result_t pending [$];
    int          errors;

    function new();
      policy = rtd_pkg::POL_FCFS;
      quantum = rtd_pkg::QUANTUM_RESET;
      front_seq = rtd_pkg::SEQ_MID;
      back_seq = rtd_pkg::SEQ_MID;
      arrival_total = '0;
      wait_total = '0;
      errors = 0;
      for (int i = 0; i < SLOTS; i++) valid[i] = 0;
      for (int c = 0; c < CPUS; c++) begin
        busy[c] = 0;
        running[c] = '0;
      end
    endfunction

    function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? rtd_pkg::MAX48 : s[47:0];
    endfunction

    function int pick(bit by_burst);
      int best;
      logic [15:0] best_key, key;
      bit take;
      best = -1;
      best_key = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!valid[i]) continue;
        key = order[i] - front_seq;
        if (best < 0) take = 1;
        else if (by_burst)
          take = burst[i] < burst[best] || (burst[i] == burst[best] && key < best_key);
        else take = key < best_key;
        if (take) begin
          best = i;
          best_key = key;
        end
      end
      return best;
    endfunction

    function int table_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += valid[i];
      return n;
    endfunction

    function void note_word(word_t w);
      rtd_pkg::result_t r;
      int p, f;
      bit srtf;
      logic [15:0] c_burst;
      logic [31:0] c_entered;
      bit c_cut;
      r = '0;
      r.status = rtd_pkg::ST_NONE;
      if (w.command == rtd_pkg::CMD_ADMIT) begin
        f = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!valid[i]) f = i;
        if (f < 0) r.status = rtd_pkg::ST_FULL;
        else begin
          valid[f] = 1;
          proc[f] = w.proc_id;
          burst[f] = w.burst_len;
          entered[f] = w.now;
          was_cut[f] = w.resumed;
          order[f] = back_seq;
          back_seq = back_seq + 16'd1;
          r.status = rtd_pkg::ST_OK;
        end
      end else if (w.command == rtd_pkg::CMD_SCHEDULE && w.cpu_index < CPUS) begin
        srtf = (policy == rtd_pkg::POL_SRTF);
        p = pick(policy >= rtd_pkg::POL_SJF);
        if (!srtf && busy[w.cpu_index]) r.status = rtd_pkg::ST_BUSY;
        else if (p < 0) r.status = rtd_pkg::ST_NONE;
        else if (srtf && busy[w.cpu_index] && w.running_left <= burst[p])
          r.status = rtd_pkg::ST_BUSY;
        else begin
          c_burst = burst[p];
          c_entered = entered[p];
          c_cut = was_cut[p];
          r.chosen_id = proc[p];
          valid[p] = 0;
          if (srtf && busy[w.cpu_index]) begin
            // The runner goes back to the head of the list in the freed slot.
            r.did_preempt = 1;
            r.preempted_id = running[w.cpu_index];
            front_seq = front_seq - 16'd1;
            valid[p] = 1;
            proc[p] = running[w.cpu_index];
            burst[p] = w.running_left;
            entered[p] = w.now;
            was_cut[p] = 1;
            order[p] = front_seq;
          end
          if (policy == rtd_pkg::POL_FCFS || policy == rtd_pkg::POL_SJF || !c_cut)
            arrival_total = sat_add(arrival_total, {16'd0, w.now});
          if (w.now >= c_entered)
            wait_total = sat_add(wait_total, {16'd0, w.now - c_entered});
          r.slice_len = c_burst;
          if (policy == rtd_pkg::POL_RR && c_burst > quantum) begin
            r.slice_len = quantum;
            r.left_over = c_burst - quantum;
          end
          busy[w.cpu_index] = 1;
          running[w.cpu_index] = r.chosen_id;
          r.dispatched = 1;
          r.status = rtd_pkg::ST_OK;
          if (table_count() == 0) begin
            front_seq = rtd_pkg::SEQ_MID;
            back_seq = rtd_pkg::SEQ_MID;
          end
        end
      end else if (w.command == rtd_pkg::CMD_RELEASE && w.cpu_index < CPUS) begin
        busy[w.cpu_index] = 0;
        running[w.cpu_index] = '0;
        r.status = rtd_pkg::ST_OK;
      end
      r.arrival_sum = arrival_total;
      r.wait_sum = wait_total;
      pending.push_back(r);
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(rtd_pkg::result_t got);
      rtd_pkg::result_t e;
      if (pending.size() == 0) begin
        report("unexpected word", '0, '0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) report("status", got.status, e.status);
      if (got.dispatched !== e.dispatched) report("dispatched", got.dispatched, e.dispatched);
      if (got.chosen_id !== e.chosen_id) report("chosen_id", got.chosen_id, e.chosen_id);
      if (got.slice_len !== e.slice_len) report("slice_len", got.slice_len, e.slice_len);
      if (got.left_over !== e.left_over) report("left_over", got.left_over, e.left_over);
      if (got.did_preempt !== e.did_preempt)
        report("did_preempt", got.did_preempt, e.did_preempt);
      if (got.preempted_id !== e.preempted_id)
        report("preempted_id", got.preempted_id, e.preempted_id);
      if (got.arrival_sum !== e.arrival_sum)
        report("arrival_sum", got.arrival_sum, e.arrival_sum);
      if (got.wait_sum !== e.wait_sum) report("wait_sum", got.wait_sum, e.wait_sum);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_command = '0, in_cpu_index = '0;
  logic [15:0] in_proc_id = '0, in_burst_len = '0, in_running_left = '0;
  logic in_resumed = 0;
  logic [31:0] in_now = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic out_dispatched, out_did_preempt;
  logic [15:0] out_chosen_id, out_slice_len, out_left_over, out_preempted_id;
  logic [47:0] out_arrival_sum, out_wait_sum;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dispatch_scoreboard tracker = new();
  bit stim_done = 0;
  bit stall_free = 0;
  int idle_cycles = 0;
  logic [31:0] clock_ticks = 32'd1000;
  int pid_next = 1;

  ready_table_cpu_dispatcher_unit u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid stays up after acceptance so that a word with no gap follows at once.
  task automatic send_word(word_t w);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    {in_command, in_cpu_index, in_proc_id, in_burst_len, in_resumed, in_now,
     in_running_left} <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_word(w);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx[0], 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == rtd_pkg::REG_POLICY) tracker.policy = value[1:0];
    else tracker.quantum = value[15:0];
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic word_t make_word(logic [1:0] cmd);
    word_t w;
    w.command = cmd;
    w.cpu_index = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) w.proc_id = 16'($urandom);
    else begin
      w.proc_id = 16'(pid_next);
      pid_next = pid_next + 1;
    end
    case ($urandom_range(0, 5))
      0: w.burst_len = 16'hFFFF;
      1: w.burst_len = 16'd1;
      2: w.burst_len = 16'($urandom);
      default: w.burst_len = 16'($urandom_range(1, 20));
    endcase
    w.resumed = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) w.now = $urandom;
    else begin
      clock_ticks = clock_ticks + $urandom_range(0, 50);
      w.now = clock_ticks;
    end
    w.running_left = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25));
    return w;
  endfunction

  // Mostly admits and schedules, with releases to free CPUs and a few bad commands.
  task automatic random_phase(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 42) send_word(make_word(rtd_pkg::CMD_ADMIT));
      else if (r < 75) send_word(make_word(rtd_pkg::CMD_SCHEDULE));
      else if (r < 97) send_word(make_word(rtd_pkg::CMD_RELEASE));
      else send_word(make_word(CMD_BAD));
    end
  endtask

  task automatic directed_phase();
    word_t w;
    w = make_word(rtd_pkg::CMD_SCHEDULE);
    send_word(w);                       // empty table
    for (int i = 0; i < SLOTS + 1; i++) begin
      w = make_word(rtd_pkg::CMD_ADMIT);
      w.burst_len = (i == 0) ? 16'hFFFF : 16'd1 + 16'(i % 3);
      w.proc_id = (i == 1) ? 16'hFFFF : 16'(i);
      w.now = (i == 2) ? 32'hFFFF_FFFF : 32'(i);
      send_word(w);                     // last one hits a full table
    end
    w = make_word(rtd_pkg::CMD_SCHEDULE);
    w.cpu_index = 0;
    send_word(w);
    send_word(w);                       // busy CPU
    w.command = rtd_pkg::CMD_RELEASE;
    send_word(w);
    send_word(w);                       // release of an idle CPU
    w.command = CMD_BAD;
    send_word(w);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed_phase();
    drain();
    write_reg(rtd_pkg::REG_POLICY, 32'(rtd_pkg::POL_RR));
    write_reg(rtd_pkg::REG_SLICE, 32'd0);
    random_phase(150);
    drain();
    write_reg(rtd_pkg::REG_SLICE, 32'd65535);
    random_phase(150);
    drain();
    write_reg(rtd_pkg::REG_SLICE, 32'd3);
    random_phase(200);
    drain();
    write_reg(rtd_pkg::REG_POLICY, 32'(rtd_pkg::POL_SJF));
    random_phase(250);
    // The sender waits here until every outstanding result has come back.
    in_valid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    random_phase(50);
    drain();
    write_reg(rtd_pkg::REG_POLICY, 32'(rtd_pkg::POL_SRTF));
    stall_free = 1;
    random_phase(100);
    stall_free = 0;
    random_phase(250);
    drain();
    write_reg(rtd_pkg::REG_POLICY, 32'(rtd_pkg::POL_FCFS));
    random_phase(250);
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (stall_free) out_ready <= 1;
      else if (hold > 0) hold--;
      else begin
        out_ready <= !out_ready;
        hold = out_ready ? gap_len() : $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result({out_status, out_dispatched, out_chosen_id, out_slice_len,
                            out_left_over, out_did_preempt, out_preempted_id,
                            out_arrival_sum, out_wait_sum});
  end

  initial begin
    while (!stim_done || tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("ready_table_cpu_dispatcher_unit_tb passed");
    else
      $display("ready_table_cpu_dispatcher_unit_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ready_table_cpu_dispatcher_unit_tb failed");
      $finish;
    end
  end
endmodule
